// ----- sv/bounded_double_ended_queue_unit_macros.svh -----
// assertion macros used by the checker file dbq_checker.sv
// expects clk and arst_n in the scope of each use
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define DBQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define DBQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/dbq_pkg.sv -----
// shared sizes, codes and controller types for the double-ended queue
// no dependencies
`default_nettype none

package dbq_pkg;

	localparam int DEPTH  = 16;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = PTR_W + 1;
	localparam int WORD_W = 32;
	localparam int OP_W   = 2;
	localparam int ST_W   = 2;

	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_DONE = 3'b100
	} state_t;

	typedef struct packed {
		logic accept;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic needs_read;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

// ----- sv/dbq_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module dbq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ----- sv/dbq_ctrl.sv -----
// request sequencer for the double-ended queue
// depends on dbq_pkg
`default_nettype none

module dbq_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire dbq_pkg::stat_t stat,
	output dbq_pkg::cmd_t     cmd
);

	import dbq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d      = state_q;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		in_stall     = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = stat.needs_read ? S_READ : S_DONE;
				end
			end
			S_READ: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/dbq_datapath.sv -----
// ring pointers, word store and result register of the double-ended queue
// depends on dbq_pkg and dbq_ram
`default_nettype none

module dbq_datapath (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dbq_pkg::cmd_t                      cmd,
	output dbq_pkg::stat_t                          stat,
	input  wire logic        [dbq_pkg::OP_W-1:0]    operation,
	input  wire logic signed [dbq_pkg::WORD_W-1:0]  data_in,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic             [dbq_pkg::ST_W-1:0]    status,
	output logic signed      [dbq_pkg::WORD_W-1:0]  data_out,
	output logic             [dbq_pkg::CNT_W-1:0]   fill_count
);

	import dbq_pkg::*;

	logic [PTR_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [ST_W-1:0]   res_status_q;
	logic              pop_ok_q;
	logic              out_valid_q;
	logic [ST_W-1:0]   status_q;
	logic [WORD_W-1:0] data_out_q;
	logic [CNT_W-1:0]  fill_q;

	logic              is_push;
	logic              is_full;
	logic              is_empty;
	logic [SUM_W-1:0]  back_sum;
	logic [SUM_W-1:0]  last_sum;
	logic [PTR_W-1:0]  back_pos;
	logic [PTR_W-1:0]  last_pos;
	logic [PTR_W-1:0]  head_dec;
	logic [PTR_W-1:0]  head_inc;
	logic              push_ok;
	logic              pop_ok;
	logic              wr_en;
	logic [PTR_W-1:0]  wr_addr;
	logic [PTR_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data;

	assign is_push  = (operation == OP_PUSH_BACK) || (operation == OP_PUSH_FRONT);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign push_ok  = is_push && !is_full;
	assign pop_ok   = !is_push && !is_empty;

	assign back_sum = SUM_W'(head_q) + SUM_W'(count_q);
	assign last_sum = SUM_W'(head_q) + SUM_W'(count_q - CNT_W'(1));
	assign back_pos = (back_sum >= SUM_W'(DEPTH)) ? PTR_W'(back_sum - SUM_W'(DEPTH))
		: PTR_W'(back_sum);
	assign last_pos = (last_sum >= SUM_W'(DEPTH)) ? PTR_W'(last_sum - SUM_W'(DEPTH))
		: PTR_W'(last_sum);
	assign head_dec = (head_q == '0) ? PTR_W'(DEPTH - 1) : head_q - PTR_W'(1);
	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + PTR_W'(1);

	assign wr_en   = cmd.accept && push_ok;
	assign wr_addr = (operation == OP_PUSH_FRONT) ? head_dec : back_pos;
	assign rd_addr = (operation == OP_POP_FRONT) ? head_q : last_pos;

	dbq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (data_in),
		.rd_en   (cmd.accept && pop_ok),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.accept) begin
			if (push_ok) begin
				count_q <= count_q + CNT_W'(1);
				if (operation == OP_PUSH_FRONT) begin
					head_q <= head_dec;
				end
			end else if (pop_ok) begin
				count_q <= count_q - CNT_W'(1);
				if (operation == OP_POP_FRONT) begin
					head_q <= head_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pop_ok_q <= pop_ok;
			if (is_push) begin
				res_status_q <= is_full ? ST_FULL : ST_OK;
			end else begin
				res_status_q <= is_empty ? ST_EMPTY : ST_OK;
			end
		end
		if (cmd.load_out) begin
			status_q   <= res_status_q;
			data_out_q <= pop_ok_q ? rd_data : '0;
			fill_q     <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.needs_read = pop_ok;
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign data_out   = data_out_q;
	assign fill_count = fill_q;

endmodule

`default_nettype wire

// ----- sv/bounded_double_ended_queue_unit.sv -----
// top level of the bounded double-ended queue: sequencer plus datapath
// depends on dbq_pkg, dbq_ctrl, dbq_datapath
//
// channel | handshake           | payload
// --------+---------------------+------------------------------------
// in      | in_valid / in_stall | operation, data_in
// out     | out_valid/out_stall | status, data_out, fill_count
//
// a push passes from accept to the done state, which loads the result register; a pop
// also passes a read state in between, after the registered store read
// one request at a time; in_stall stays high until the result register is loaded
// the output register holds its beat for as long as out_stall is high
// reset clears head pointer, count and control; the word store is not cleared
`default_nettype none

module bounded_double_ended_queue_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic        [dbq_pkg::OP_W-1:0]    operation,
	input  wire logic signed [dbq_pkg::WORD_W-1:0]  data_in,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic             [dbq_pkg::ST_W-1:0]    status,
	output logic signed      [dbq_pkg::WORD_W-1:0]  data_out,
	output logic             [dbq_pkg::CNT_W-1:0]   fill_count
);

	import dbq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	dbq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	dbq_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.operation  (operation),
		.data_in    (data_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.data_out   (data_out),
		.fill_count (fill_count)
	);

endmodule

`default_nettype wire

// ----- sv/dbq_checker.sv -----
// port-level checks for the bounded double-ended queue, bound to the top level
// depends on dbq_pkg and bounded_double_ended_queue_unit_macros.svh
`default_nettype none

`include "bounded_double_ended_queue_unit_macros.svh"

module dbq_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_stall,
	input  wire logic                               out_valid,
	input  wire logic                               out_stall,
	input  wire logic        [dbq_pkg::ST_W-1:0]    status,
	input  wire logic signed [dbq_pkg::WORD_W-1:0]  data_out,
	input  wire logic        [dbq_pkg::CNT_W-1:0]   fill_count
);

	import dbq_pkg::*;

	// a stalled result beat stays on offer
	`DBQ_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
	// one request in flight at a time
	`DBQ_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)
	// refused requests return a zero word
	`DBQ_ASSERT_NOW(a_refused_zero, out_valid && (status != ST_OK), data_out == '0)
	// fill count bounded
	`DBQ_ASSERT_NOW(a_fill_range, out_valid, fill_count <= CNT_W'(DEPTH))
	// status a known code
	`DBQ_ASSERT_NOW(a_status_code, out_valid, (status == ST_OK) || (status == ST_FULL) || (status == ST_EMPTY))

endmodule

bind bounded_double_ended_queue_unit dbq_checker u_dbq_checker (.*);

`default_nettype wire

// ----- dv/dbq_deque_check_pkg.sv -----
`timescale 1ns / 1ps
// scoreboard for the double-ended queue: a mirror of the ring buffer that predicts
// each result beat and checks it field by field
// depends on dbq_pkg
package dbq_deque_check_pkg;

	import dbq_pkg::*;

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic signed [WORD_W-1:0] word;
		logic [CNT_W-1:0]         fill;
	} deque_answer_t;

	class deque_mirror;
		logic signed [WORD_W-1:0] ring [DEPTH];
		int head;
		int count;
		int failures;
		deque_answer_t awaited [$];

		function new();
			head = 0;
			count = 0;
			failures = 0;
		endfunction

		function void take_request(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] word);
			deque_answer_t answer;
			answer.status = ST_OK;
			answer.word = '0;
			case (op)
				OP_PUSH_BACK, OP_PUSH_FRONT: begin
					if (count == DEPTH) begin
						answer.status = ST_FULL;
					end else begin
						if (op == OP_PUSH_BACK) begin
							ring[(head + count) % DEPTH] = word;
						end else begin
							head = (head + DEPTH - 1) % DEPTH;
							ring[head] = word;
						end
						count++;
					end
				end
				OP_POP_BACK, OP_POP_FRONT: begin
					if (count == 0) begin
						answer.status = ST_EMPTY;
					end else begin
						if (op == OP_POP_BACK) begin
							answer.word = ring[(head + count - 1) % DEPTH];
						end else begin
							answer.word = ring[head];
							head = (head + 1) % DEPTH;
						end
						count--;
					end
				end
				default: begin
				end
			endcase
			answer.fill = CNT_W'(count);
			awaited.push_back(answer);
		endfunction

		function void flag(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("@%0t %s mismatch: expected %h, got %h", $time, what, want, got);
		endfunction

		function void check_result(logic [ST_W-1:0] st, logic signed [WORD_W-1:0] word,
				logic [CNT_W-1:0] fill);
			deque_answer_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("@%0t unexpected result beat: status %0d data %h fill %0d",
						$time, st, word, fill);
				return;
			end
			want = awaited.pop_front();
			if (st !== want.status)
				flag("status", WORD_W'(want.status), WORD_W'(st));
			if (word !== want.word)
				flag("data_out", want.word, word);
			if (fill !== want.fill)
				flag("fill_count", WORD_W'(want.fill), WORD_W'(fill));
		endfunction
	endclass

endpackage

// ----- dv/bounded_double_ended_queue_unit_test.sv -----
`timescale 1ns / 1ps
// testbench for bounded_double_ended_queue_unit: directed edge cases, then random
// push/pop bursts with random idling on both sides, checked by the deque mirror
// depends on dbq_pkg, dbq_deque_check_pkg and the block under test
module bounded_double_ended_queue_unit_test;

	import dbq_pkg::*;
	import dbq_deque_check_pkg::*;

	localparam int RANDOM_ITEMS = 1430;
	localparam int TAIL_CYCLES  = 16;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [OP_W-1:0]          operation;
	logic signed [WORD_W-1:0] data_in;
	logic                     out_valid;
	logic                     out_stall;
	logic [ST_W-1:0]          status;
	logic signed [WORD_W-1:0] data_out;
	logic [CNT_W-1:0]         fill_count;

	deque_mirror mirror;
	int source_gap_max;
	int sink_stall_max;

	bounded_double_ended_queue_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.data_in    (data_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.data_out   (data_out),
		.fill_count (fill_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_request(input logic [OP_W-1:0] op, input logic signed [WORD_W-1:0] word);
		int gap;
		gap = $urandom_range(source_gap_max, 0);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		data_in <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		mirror.take_request(op, word);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (mirror.awaited.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(15, 0))
			0:       pick_word = 32'sh7fff_ffff;
			1:       pick_word = 32'sh8000_0000;
			2:       pick_word = '0;
			3:       pick_word = '1;
			default: pick_word = $urandom;
		endcase
	endfunction

	task automatic run_burst(input int length, input int push_pct);
		logic [OP_W-1:0] op;
		for (int i = 0; i < length; i++) begin
			if ($urandom_range(99, 0) < push_pct)
				op = $urandom_range(1, 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
			else
				op = $urandom_range(1, 0) ? OP_POP_FRONT : OP_POP_BACK;
			send_request(op, pick_word());
		end
	endtask

	// result side
	initial begin
		int stall_left;
		int beats;
		stall_left = 0;
		beats = 0;
		sink_stall_max = 12;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				mirror.check_result(status, data_out, fill_count);
				beats++;
				if (beats % 40 == 0) begin
					case ($urandom_range(2, 0))
						0:       sink_stall_max = 0;
						1:       sink_stall_max = 12;
						default: sink_stall_max = 3;
					endcase
				end
				stall_left = $urandom_range(sink_stall_max, 0);
			end
		end
	end

	// request side
	initial begin
		int sent;
		int length;
		int push_pct;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_PUSH_BACK;
		data_in = '0;
		mirror = new();
		source_gap_max = 12;
		sent = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// pops on an empty buffer, data ignored
		send_request(OP_POP_BACK, 32'sh1234_5678);
		send_request(OP_POP_FRONT, '1);
		// extremes at both ends, front push wraps the head below zero
		send_request(OP_PUSH_BACK, 32'sh7fff_ffff);
		send_request(OP_PUSH_FRONT, 32'sh8000_0000);
		send_request(OP_PUSH_BACK, '0);
		send_request(OP_PUSH_FRONT, '1);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_FRONT, 32'sh7fff_ffff);
		// fill to the limit, then pushes into a full buffer
		for (int i = 0; i < 14; i++)
			send_request(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
				i[1] ? 32'shaaaa_aaaa : 32'sh5555_5555);
		send_request(OP_PUSH_BACK, 32'sh0bad_f00d);
		send_request(OP_PUSH_FRONT, 32'sh8000_0000);
		wait_for_results();

		while (sent < RANDOM_ITEMS) begin
			length = $urandom_range(48, 4);
			case ($urandom_range(3, 0))
				0:       push_pct = 85;
				1:       push_pct = 15;
				2:       push_pct = 50;
				default: push_pct = 65;
			endcase
			case ($urandom_range(2, 0))
				0:       source_gap_max = 0;
				1:       source_gap_max = 12;
				default: source_gap_max = 2;
			endcase
			run_burst(length, push_pct);
			sent += length;
			if ($urandom_range(7, 0) == 0)
				wait_for_results();
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mirror.failures == 0 && mirror.awaited.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- bounded_double_ended_queue_unit.f -----
+incdir+sv
sv/dbq_pkg.sv
sv/dbq_ram.sv
sv/dbq_ctrl.sv
sv/dbq_datapath.sv
sv/bounded_double_ended_queue_unit.sv
sv/dbq_checker.sv
dv/dbq_deque_check_pkg.sv
dv/bounded_double_ended_queue_unit_test.sv
